@@ sv/bulk_only_transport_monitor_core_assert.svh @@
// Assertion macros shared by the bulk-only transport monitor RTL
`ifndef BULK_ONLY_TRANSPORT_MONITOR_CORE_ASSERT_SVH
`define BULK_ONLY_TRANSPORT_MONITOR_CORE_ASSERT_SVH

// same-cycle implication, checked on i_clk outside reset
`define BOT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define BOT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bot_pkg.sv @@
// Types and constants of the bulk-only transport monitor
package bot_pkg;

    localparam int CHANNELS     = 8;
    // only eight channels have register bits
    localparam int MAP_CHANNELS = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int SEL_W        = (MAP_CHANNELS > 1) ? $clog2(MAP_CHANNELS) : 1;
    localparam int CH_W         = 3;
    localparam int ADDR_W       = 5;

    localparam logic [15:0] CMD_WRAPPER_BYTES = 16'd31;
    localparam logic [31:0] CMD_SIGNATURE     = 32'h4342_5355;
    localparam logic [31:0] STS_SIGNATURE     = 32'h5342_5355;
    localparam logic [4:0]  MIN_CB_LENGTH     = 5'd1;
    localparam logic [4:0]  MAX_CB_LENGTH     = 5'd16;
    localparam logic [10:0] MAX_PACKET_RESET  = 11'd64;

    typedef enum logic [2:0] {
        REG_CHANNEL_ENABLE = 3'd0,
        REG_IN_EP_MAP      = 3'd1,
        REG_OUT_EP_MAP     = 3'd2,
        REG_MAX_LUN_MAP    = 3'd3,
        REG_MAX_PACKET     = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DATA   = 2'd1,
        PH_STATUS = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        EV_IGNORED      = 4'd0,
        EV_CMD_DATA     = 4'd1,
        EV_CMD_NODATA   = 4'd2,
        EV_BAD_SIZE     = 4'd3,
        EV_BAD_SIG      = 4'd4,
        EV_BAD_CBLEN    = 4'd5,
        EV_BAD_LUN      = 4'd6,
        EV_DATA         = 4'd7,
        EV_DATA_DONE    = 4'd8,
        EV_STATUS_OK    = 4'd9,
        EV_BAD_STS_SIG  = 4'd10,
        EV_TAG_MISMATCH = 4'd11,
        EV_BAD_SEQUENCE = 4'd12
    } t_event;

    typedef struct packed {
        logic        kind;
        logic [3:0]  endpoint;
        logic        transfer_ok;
        logic [15:0] byte_length;
        logic [31:0] signature;
        logic [31:0] wrapper_tag;
        logic [31:0] expected_bytes;
        logic [3:0]  lun;
        logic [4:0]  command_length;
        logic [7:0]  opcode;
        logic [7:0]  status_byte;
    } t_in_word;

    typedef struct packed {
        t_event           event_res;
        logic [CH_W-1:0]  channel;
        logic [7:0]       command_opcode;
        logic [7:0]       wrapper_status;
        logic [31:0]      bytes_so_far;
    } t_out_word;

endpackage

@@ sv/bot_in_if.sv @@
// Valid/ready channel carrying one summarized bulk transfer
interface bot_in_if;
    logic              valid;
    logic              ready;
    bot_pkg::t_in_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ sv/bot_out_if.sv @@
// Valid/ready channel carrying one monitor event
interface bot_out_if;
    logic               valid;
    logic               ready;
    bot_pkg::t_out_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ sv/bulk_only_transport_monitor_core.sv @@
// Bulk-only transport monitor: channel match, phase tracking and event output
//
//  port     | dir | handshake           | word
//  ---------+-----+---------------------+-------------------------------
//  i_in     | in  | valid/ready         | one finished bulk transfer
//  o_out    | out | valid/ready         | one event per transfer
//  apb      | in  | psel/penable/pwrite | register write, pready tied high
//
// An accepted word goes through the input register, then one pass of match, check and
// state update into the result register.
// A new word is taken every cycle unless the result is stalled; state updates land at
// the same edge the result loads, so the next word sees them.
// A stalled result holds the input register; i_in.ready drops only when both
// registers are full and o_out.ready is low.
// Synchronous active-low reset clears phases, counts, tags and registers.
module bulk_only_transport_monitor_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bot_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    bot_in_if.sink                       i_in,
    bot_out_if.source                    o_out
);

    // configuration registers
    logic [7:0]  r_enable;
    logic [31:0] r_in_ep_map;
    logic [31:0] r_out_ep_map;
    logic [31:0] r_lun_map;
    logic [10:0] r_max_packet;

    // per-channel state
    bot_pkg::t_phase r_phase    [bot_pkg::MAP_CHANNELS];
    logic [31:0]     r_count    [bot_pkg::MAP_CHANNELS];
    logic [31:0]     r_tag      [bot_pkg::MAP_CHANNELS];
    logic [31:0]     r_expected [bot_pkg::MAP_CHANNELS];

    logic               r_in_valid;
    bot_pkg::t_in_word  r_in;
    logic               r_out_valid;
    bot_pkg::t_out_word r_out;

    logic                     w_advance;
    logic                     w_cfg_write;
    bot_pkg::t_reg_idx        w_reg_idx;
    logic [31:0]              w_map;
    logic                     w_found;
    logic [bot_pkg::SEL_W-1:0] w_sel;
    bot_pkg::t_phase          w_phase_cur;
    logic [31:0]              w_count_cur;
    logic [32:0]              w_sum_wide;
    logic [31:0]              w_sum;
    logic                     w_data_end;
    logic                     w_cblen_bad;
    logic                     w_lun_bad;
    bot_pkg::t_event          w_event;
    bot_pkg::t_phase          n_phase;
    logic [31:0]              n_count;
    logic                     w_save_cmd;
    bot_pkg::t_out_word       n_out;

    // ---------------- handshake ----------------
    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // ---------------- configuration ----------------
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;
    assign w_reg_idx   = bot_pkg::t_reg_idx'(paddr[bot_pkg::ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= '0;
            r_in_ep_map  <= '0;
            r_out_ep_map <= '0;
            r_lun_map    <= '0;
            r_max_packet <= bot_pkg::MAX_PACKET_RESET;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                bot_pkg::REG_CHANNEL_ENABLE: r_enable     <= pwdata[7:0];
                bot_pkg::REG_IN_EP_MAP:      r_in_ep_map  <= pwdata;
                bot_pkg::REG_OUT_EP_MAP:     r_out_ep_map <= pwdata;
                bot_pkg::REG_MAX_LUN_MAP:    r_lun_map    <= pwdata;
                bot_pkg::REG_MAX_PACKET:     r_max_packet <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            bot_pkg::REG_CHANNEL_ENABLE: prdata = {24'd0, r_enable};
            bot_pkg::REG_IN_EP_MAP:      prdata = r_in_ep_map;
            bot_pkg::REG_OUT_EP_MAP:     prdata = r_out_ep_map;
            bot_pkg::REG_MAX_LUN_MAP:    prdata = r_lun_map;
            bot_pkg::REG_MAX_PACKET:     prdata = {21'd0, r_max_packet};
            default:                     prdata = '0;
        endcase
    end

    // ---------------- channel match ----------------
    assign w_map = r_in.kind ? r_in_ep_map : r_out_ep_map;

    // scan from the top so the lowest matching channel wins
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int i = bot_pkg::MAP_CHANNELS - 1; i >= 0; i--) begin
            if (r_enable[i] && (w_map[4*i +: 4] == r_in.endpoint)) begin
                w_found = 1'b1;
                w_sel   = bot_pkg::SEL_W'(i);
            end
        end
    end

    assign w_phase_cur = r_phase[w_sel];
    assign w_count_cur = r_count[w_sel];

    // saturating byte count
    assign w_sum_wide = {1'b0, w_count_cur} + {17'd0, r_in.byte_length};
    assign w_sum      = w_sum_wide[32] ? 32'hFFFF_FFFF : w_sum_wide[31:0];
    assign w_data_end = (r_in.byte_length < {5'd0, r_max_packet})
                     || (w_sum >= r_expected[w_sel])
                     || (r_in.kind && !r_in.transfer_ok);

    assign w_cblen_bad = (r_in.command_length < bot_pkg::MIN_CB_LENGTH)
                      || (r_in.command_length > bot_pkg::MAX_CB_LENGTH);
    assign w_lun_bad   = r_in.lun > r_lun_map[{w_sel, 2'b00} +: 4];

    // ---------------- event decision ----------------
    always_comb begin
        w_event = bot_pkg::EV_IGNORED;
        if (w_found) begin
            unique case (w_phase_cur)
                bot_pkg::PH_DATA: begin
                    w_event = w_data_end ? bot_pkg::EV_DATA_DONE : bot_pkg::EV_DATA;
                end
                bot_pkg::PH_IDLE: begin
                    if (r_in.kind) begin
                        w_event = bot_pkg::EV_BAD_SEQUENCE;
                    end else if (r_in.byte_length != bot_pkg::CMD_WRAPPER_BYTES) begin
                        w_event = bot_pkg::EV_BAD_SIZE;
                    end else if (r_in.signature != bot_pkg::CMD_SIGNATURE) begin
                        w_event = bot_pkg::EV_BAD_SIG;
                    end else if (w_cblen_bad) begin
                        w_event = bot_pkg::EV_BAD_CBLEN;
                    end else if (w_lun_bad) begin
                        w_event = bot_pkg::EV_BAD_LUN;
                    end else if (r_in.expected_bytes == 32'd0) begin
                        w_event = bot_pkg::EV_CMD_NODATA;
                    end else begin
                        w_event = bot_pkg::EV_CMD_DATA;
                    end
                end
                bot_pkg::PH_STATUS: begin
                    if (!r_in.kind) begin
                        w_event = bot_pkg::EV_BAD_SEQUENCE;
                    end else if (r_in.signature != bot_pkg::STS_SIGNATURE) begin
                        w_event = bot_pkg::EV_BAD_STS_SIG;
                    end else if (r_in.wrapper_tag != r_tag[w_sel]) begin
                        w_event = bot_pkg::EV_TAG_MISMATCH;
                    end else begin
                        w_event = bot_pkg::EV_STATUS_OK;
                    end
                end
                default: w_event = bot_pkg::EV_BAD_SEQUENCE;
            endcase
        end
    end

    // ---------------- next state of the matched channel ----------------
    always_comb begin
        n_phase    = w_phase_cur;
        n_count    = w_count_cur;
        w_save_cmd = 1'b0;
        case (w_event) inside
            bot_pkg::EV_CMD_DATA: begin
                n_phase    = bot_pkg::PH_DATA;
                n_count    = '0;
                w_save_cmd = 1'b1;
            end
            bot_pkg::EV_CMD_NODATA: begin
                n_phase    = bot_pkg::PH_STATUS;
                n_count    = '0;
                w_save_cmd = 1'b1;
            end
            // wrapper of right size: tag and length saved even when a check fails
            bot_pkg::EV_BAD_SIG, bot_pkg::EV_BAD_CBLEN, bot_pkg::EV_BAD_LUN: begin
                n_count    = '0;
                w_save_cmd = 1'b1;
            end
            bot_pkg::EV_DATA: begin
                n_count = w_sum;
            end
            bot_pkg::EV_DATA_DONE: begin
                n_phase = bot_pkg::PH_STATUS;
                n_count = w_sum;
            end
            bot_pkg::EV_STATUS_OK, bot_pkg::EV_BAD_STS_SIG, bot_pkg::EV_TAG_MISMATCH: begin
                n_phase = bot_pkg::PH_IDLE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bot_pkg::MAP_CHANNELS; i++) begin
                r_phase[i]    <= bot_pkg::PH_IDLE;
                r_count[i]    <= '0;
                r_tag[i]      <= '0;
                r_expected[i] <= '0;
            end
        end else if (w_advance && w_found) begin
            r_phase[w_sel] <= n_phase;
            r_count[w_sel] <= n_count;
            if (w_save_cmd) begin
                r_tag[w_sel]      <= r_in.wrapper_tag;
                r_expected[w_sel] <= r_in.expected_bytes;
            end
        end
    end

    // ---------------- result word ----------------
    always_comb begin
        n_out                = '0;
        n_out.event_res      = w_event;
        n_out.channel        = w_found ? bot_pkg::CH_W'(w_sel) : '0;
        n_out.bytes_so_far   = w_found ? n_count : '0;
        case (w_event) inside
            bot_pkg::EV_CMD_DATA, bot_pkg::EV_CMD_NODATA: begin
                n_out.command_opcode = r_in.opcode;
            end
            bot_pkg::EV_STATUS_OK: begin
                n_out.wrapper_status = r_in.status_byte;
            end
            default: ;
        endcase
    end

    // ---------------- assertions ----------------
    `include "bulk_only_transport_monitor_core_assert.svh"

    `BOT_ASSERT_NOW(a_ignored_zero, r_out_valid && (r_out.event_res == bot_pkg::EV_IGNORED), (r_out.channel == '0) && (r_out.bytes_so_far == '0), "ignored event with nonzero fields")
    `BOT_ASSERT_NOW(a_status_echo, r_out_valid && (r_out.wrapper_status != '0), r_out.event_res == bot_pkg::EV_STATUS_OK, "status byte echoed outside status ok")
    `BOT_ASSERT_NOW(a_opcode_echo, r_out_valid && (r_out.command_opcode != '0), (r_out.event_res == bot_pkg::EV_CMD_DATA) || (r_out.event_res == bot_pkg::EV_CMD_NODATA), "opcode echoed outside command ok")
    `BOT_ASSERT_NEXT(a_input_held, r_in_valid && !w_advance, r_in_valid, "pending transfer dropped")

endmodule
